FILE: hw/rtl/triangle_box_area_ratio_classify_unit_defines.svh
// Assertion helpers used by the checker file.
`ifndef TRIANGLE_BOX_AREA_RATIO_CLASSIFY_UNIT_DEFINES_SVH
`define TRIANGLE_BOX_AREA_RATIO_CLASSIFY_UNIT_DEFINES_SVH

// expr holds at every edge outside reset
`define TBAR_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("tbar check failed");

// ante at one edge implies cons at the next
`define TBAR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tbar check failed");

`endif

FILE: hw/rtl/tbar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tbar_pkg;

  localparam int unsigned COORD_BITS = 20;
  localparam int unsigned ID_BITS    = 24;
  localparam int unsigned RAT_BITS   = 32;
  localparam int unsigned KEY_BITS   = 64;

  // edge vectors, box extents, cross product
  localparam int unsigned EW  = COORD_BITS + 1;
  localparam int unsigned XW  = COORD_BITS;
  localparam int unsigned PRW = 2 * EW;
  localparam int unsigned MW  = 2 * COORD_BITS + 1;
  localparam int unsigned ML  = MW / 2;
  localparam int unsigned MH  = MW - ML;
  // squared length and its root
  localparam int unsigned SW  = 2 * MW + 2;
  localparam int unsigned RW  = SW / 2;
  localparam int unsigned TRW = RW - 1;
  // box surface area, split for the key multiply
  localparam int unsigned SAW = 2 * COORD_BITS + 3;
  localparam int unsigned SL  = SAW / 2;
  localparam int unsigned SH  = SAW - SL;
  // divider remainder and key product
  localparam int unsigned DW  = TRW + RAT_BITS;
  localparam int unsigned OW  = TRW + 16;
  localparam int unsigned PW  = SAW + RAT_BITS;
  localparam int unsigned PXW = (PW > 81) ? PW : 81;

  localparam logic [RAT_BITS-1:0] THR_RESET = 32'h0010_0000;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t             ax;
    coord_t             ay;
    coord_t             az;
    coord_t             bx;
    coord_t             by_coord;
    coord_t             bz;
    coord_t             cx;
    coord_t             cy;
    coord_t             cz;
    logic [ID_BITS-1:0] tri_id;
    logic               last_in;
  } tri_in_t;

  typedef struct packed {
    coord_t              min_x;
    coord_t              min_y;
    coord_t              min_z;
    coord_t              max_x;
    coord_t              max_y;
    coord_t              max_z;
    logic [ID_BITS-1:0]  tri_id_out;
    logic                selected;
    logic [RAT_BITS-1:0] area_ratio;
    logic [KEY_BITS-1:0] priority_key;
    logic                last_out;
  } tri_out_t;

  // data that rides along the whole pipe
  typedef struct packed {
    coord_t             min_x;
    coord_t             min_y;
    coord_t             min_z;
    coord_t             max_x;
    coord_t             max_y;
    coord_t             max_z;
    logic [ID_BITS-1:0] tri_id;
    logic               last;
  } side_t;

  // word handed between square root cells
  typedef struct packed {
    side_t          side;
    logic [SAW-1:0] sa;
    logic [SW-1:0]  rem;
    logic [RW-1:0]  root;
  } sq_t;

  // word handed between divider cells
  typedef struct packed {
    side_t               side;
    logic [SAW-1:0]      sa;
    logic [DW-1:0]       rem;
    logic [TRW-1:0]      tri_area;
    logic                ovf;
    logic [RAT_BITS-1:0] quo;
  } dv_t;

  function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/triangle_box_area_ratio_classify_unit.sv
// Channel   Direction  Handshake             Word
// in        input      in_valid_i/in_ready_o   tri_in_t: vertices, id, last flag
// out       output     out_valid_o/out_ready_i tri_out_t: box, ratio, key, flags
// cfg       input      cfg_valid_i/cfg_ready_o 32-bit threshold_ratio, Q16.16
//
// One triangle per cycle in and out unless the output stalls. Stages: 5 front
// stages, 42 square root cells, 1 divider setup stage, 32 divider cells, key
// multiply and output; the root and quotient chains form one bit per cell.
// The whole pipe advances when the output register is empty or taken; in_ready_o
// follows that. Reset clears valid bits and loads threshold 16.0; cfg always ready.
`timescale 1ns / 1ps
`default_nettype none
module triangle_box_area_ratio_classify_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tbar_pkg::tri_in_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tbar_pkg::tri_out_t   out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [31:0]          cfg_data_i
);
  import tbar_pkg::*;

  logic adv;
  logic [RAT_BITS-1:0] thr_q;

  // stage valid bits
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, sp_v_q, sm_v_q, out_v_q;

  side_t s1_side_q, s2_side_q, s3_side_q, s4_side_q, sm_side_q;
  logic [XW-1:0]         s1_ext_q [3];
  logic signed [EW-1:0]  s1_e1_q [3];
  logic signed [EW-1:0]  s1_e2_q [3];
  logic [2*XW-1:0]       s2_pe_q [3];
  logic signed [PRW-1:0] s2_pa_q [3];
  logic signed [PRW-1:0] s2_pb_q [3];
  logic [SAW-1:0]        s3_sa_q, s4_sa_q;
  logic [MW-1:0]         s3_mag_q [3];
  logic [2*MH-1:0]       s4_hh_q [3];
  logic [MH+ML-1:0]      s4_hl_q [3];
  logic [2*ML-1:0]       s4_ll_q [3];
  sq_t                   s5_q;
  dv_t                   sp_q;
  logic [RAT_BITS-1:0]   sm_ratio_q;
  logic [SH+RAT_BITS-1:0] sm_ph_q;
  logic [SL+RAT_BITS-1:0] sm_pl_q;
  tri_out_t              out_q;

  // cell chains
  logic sq_v [RW+1];
  sq_t  sq_w [RW+1];
  logic dv_v [RAT_BITS+1];
  dv_t  dv_w [RAT_BITS+1];

  assign adv         = !out_v_q || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // valid bits for the front, setup, multiply and output stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      sp_v_q  <= 1'b0;
      sm_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      s5_v_q  <= s4_v_q;
      sp_v_q  <= sq_v[RW];
      sm_v_q  <= dv_v[RAT_BITS];
      out_v_q <= sm_v_q;
    end
  end

  // stage 1: bounding box, extents, edge vectors
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_side_q.min_x  <= min3(in_data_i.ax, in_data_i.bx, in_data_i.cx);
      s1_side_q.min_y  <= min3(in_data_i.ay, in_data_i.by_coord, in_data_i.cy);
      s1_side_q.min_z  <= min3(in_data_i.az, in_data_i.bz, in_data_i.cz);
      s1_side_q.max_x  <= max3(in_data_i.ax, in_data_i.bx, in_data_i.cx);
      s1_side_q.max_y  <= max3(in_data_i.ay, in_data_i.by_coord, in_data_i.cy);
      s1_side_q.max_z  <= max3(in_data_i.az, in_data_i.bz, in_data_i.cz);
      s1_side_q.tri_id <= in_data_i.tri_id;
      s1_side_q.last   <= in_data_i.last_in;
      s1_ext_q[0] <= XW'(EW'(max3(in_data_i.ax, in_data_i.bx, in_data_i.cx))
                       - EW'(min3(in_data_i.ax, in_data_i.bx, in_data_i.cx)));
      s1_ext_q[1] <= XW'(EW'(max3(in_data_i.ay, in_data_i.by_coord, in_data_i.cy))
                       - EW'(min3(in_data_i.ay, in_data_i.by_coord, in_data_i.cy)));
      s1_ext_q[2] <= XW'(EW'(max3(in_data_i.az, in_data_i.bz, in_data_i.cz))
                       - EW'(min3(in_data_i.az, in_data_i.bz, in_data_i.cz)));
      s1_e1_q[0] <= EW'(in_data_i.ax) - EW'(in_data_i.bx);
      s1_e1_q[1] <= EW'(in_data_i.ay) - EW'(in_data_i.by_coord);
      s1_e1_q[2] <= EW'(in_data_i.az) - EW'(in_data_i.bz);
      s1_e2_q[0] <= EW'(in_data_i.ax) - EW'(in_data_i.cx);
      s1_e2_q[1] <= EW'(in_data_i.ay) - EW'(in_data_i.cy);
      s1_e2_q[2] <= EW'(in_data_i.az) - EW'(in_data_i.cz);
    end
  end

  // stage 2: extent products and cross product terms
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_side_q  <= s1_side_q;
      s2_pe_q[0] <= (2*XW)'(s1_ext_q[0]) * (2*XW)'(s1_ext_q[1]);
      s2_pe_q[1] <= (2*XW)'(s1_ext_q[1]) * (2*XW)'(s1_ext_q[2]);
      s2_pe_q[2] <= (2*XW)'(s1_ext_q[2]) * (2*XW)'(s1_ext_q[0]);
      s2_pa_q[0] <= s1_e1_q[1] * s1_e2_q[2];
      s2_pb_q[0] <= s1_e1_q[2] * s1_e2_q[1];
      s2_pa_q[1] <= s1_e1_q[2] * s1_e2_q[0];
      s2_pb_q[1] <= s1_e1_q[0] * s1_e2_q[2];
      s2_pa_q[2] <= s1_e1_q[0] * s1_e2_q[1];
      s2_pb_q[2] <= s1_e1_q[1] * s1_e2_q[0];
    end
  end

  // stage 3: surface area, cross product magnitudes
  logic [SAW-2:0]        sa_half;
  logic signed [PRW-1:0] cr [3];
  always_comb begin
    sa_half = (SAW-1)'(s2_pe_q[0]) + (SAW-1)'(s2_pe_q[1]) + (SAW-1)'(s2_pe_q[2]);
    for (int k = 0; k < 3; k++) begin
      cr[k] = s2_pa_q[k] - s2_pb_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_side_q <= s2_side_q;
      s3_sa_q   <= {sa_half, 1'b0};
      for (int k = 0; k < 3; k++) begin
        s3_mag_q[k] <= MW'(cr[k][PRW-1] ? -cr[k] : cr[k]);
      end
    end
  end

  // stage 4: partial products of each square
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_side_q <= s3_side_q;
      s4_sa_q   <= s3_sa_q;
      for (int k = 0; k < 3; k++) begin
        s4_hh_q[k] <= (2*MH)'(s3_mag_q[k][MW-1:ML]) * (2*MH)'(s3_mag_q[k][MW-1:ML]);
        s4_hl_q[k] <= (MH+ML)'(s3_mag_q[k][MW-1:ML]) * (MH+ML)'(s3_mag_q[k][ML-1:0]);
        s4_ll_q[k] <= (2*ML)'(s3_mag_q[k][ML-1:0]) * (2*ML)'(s3_mag_q[k][ML-1:0]);
      end
    end
  end

  // stage 5: squared cross length, seeds the root chain
  logic [SW-1:0] sq_sum;
  always_comb begin
    sq_sum = '0;
    for (int k = 0; k < 3; k++) begin
      sq_sum = sq_sum + (SW'(s4_hh_q[k]) << (2 * ML))
                      + (SW'(s4_hl_q[k]) << (ML + 1)) + SW'(s4_ll_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_q.side <= s4_side_q;
      s5_q.sa   <= s4_sa_q;
      s5_q.rem  <= sq_sum;
      s5_q.root <= '0;
    end
  end

  assign sq_v[0] = s5_v_q;
  assign sq_w[0] = s5_q;

  // square root: one result bit per cell, top bit first
  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    tbar_sqrt_cell #(
      .BIT(RW - 1 - g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(sq_v[g]),
      .data_i (sq_w[g]),
      .valid_o(sq_v[g+1]),
      .data_o (sq_w[g+1])
    );
  end

  // divider setup: triangle area, overflow check, scaled dividend
  logic [TRW-1:0] tri_a;
  always_comb begin
    tri_a = sq_w[RW].root[RW-1:1];
    if (tri_a == '0) begin
      tri_a = TRW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sp_q.side     <= sq_w[RW].side;
      sp_q.sa       <= sq_w[RW].sa;
      sp_q.rem      <= DW'(sq_w[RW].sa) << 16;
      sp_q.tri_area <= tri_a;
      sp_q.ovf      <= OW'(sq_w[RW].sa) >= (OW'(tri_a) << 16);
      sp_q.quo      <= '0;
    end
  end

  assign dv_v[0] = sp_v_q;
  assign dv_w[0] = sp_q;

  // ratio division: one quotient bit per cell
  for (genvar g = 0; g < RAT_BITS; g++) begin : g_div
    tbar_div_cell #(
      .BIT(RAT_BITS - 1 - g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(dv_v[g]),
      .data_i (dv_w[g]),
      .valid_o(dv_v[g+1]),
      .data_o (dv_w[g+1])
    );
  end

  // key multiply, area split in two halves
  logic [RAT_BITS-1:0] ratio;
  assign ratio = dv_w[RAT_BITS].ovf ? '1 : dv_w[RAT_BITS].quo;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sm_side_q  <= dv_w[RAT_BITS].side;
      sm_ratio_q <= ratio;
      sm_ph_q    <= (SH+RAT_BITS)'(dv_w[RAT_BITS].sa[SAW-1:SL]) * (SH+RAT_BITS)'(ratio);
      sm_pl_q    <= (SL+RAT_BITS)'(dv_w[RAT_BITS].sa[SL-1:0]) * (SL+RAT_BITS)'(ratio);
    end
  end

  // output word: key with saturation, selection
  logic [PXW-1:0] prod;
  always_comb begin
    prod = (PXW'(sm_ph_q) << SL) + PXW'(sm_pl_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.min_x        <= sm_side_q.min_x;
      out_q.min_y        <= sm_side_q.min_y;
      out_q.min_z        <= sm_side_q.min_z;
      out_q.max_x        <= sm_side_q.max_x;
      out_q.max_y        <= sm_side_q.max_y;
      out_q.max_z        <= sm_side_q.max_z;
      out_q.tri_id_out   <= sm_side_q.tri_id;
      out_q.last_out     <= sm_side_q.last;
      out_q.area_ratio   <= sm_ratio_q;
      out_q.selected     <= sm_ratio_q > thr_q;
      out_q.priority_key <= (|prod[PXW-1:80]) ? '1 : prod[79:16];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: hw/rtl/tbar_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module tbar_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  tbar_pkg::sq_t data_i,
  output logic          valid_o,
  output tbar_pkg::sq_t data_o
);
  import tbar_pkg::*;

  localparam int unsigned TW = SW + 2;

  logic [TW-1:0] trial;
  logic          take;
  sq_t           nxt;
  logic          valid_q;
  sq_t           data_q;

  // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b); root holds only bits above b
  always_comb begin
    trial = (TW'(data_i.root) << (BIT + 1)) | (TW'(1) << (2 * BIT));
    take  = TW'(data_i.rem) >= trial;
    nxt   = data_i;
    if (take) begin
      nxt.rem  = data_i.rem - SW'(trial);
      nxt.root = data_i.root | (RW'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= nxt;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

FILE: hw/rtl/tbar_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module tbar_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  tbar_pkg::dv_t data_i,
  output logic          valid_o,
  output tbar_pkg::dv_t data_o
);
  import tbar_pkg::*;

  logic [DW-1:0] dsr;
  logic          take;
  dv_t           nxt;
  logic          valid_q;
  dv_t           data_q;

  // restoring step: subtract divisor aligned to this quotient bit
  always_comb begin
    dsr  = DW'(data_i.tri_area) << BIT;
    take = data_i.rem >= dsr;
    nxt  = data_i;
    if (take) begin
      nxt.rem = data_i.rem - dsr;
      nxt.quo = data_i.quo | (RAT_BITS'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= nxt;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

FILE: hw/rtl/tbar_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_box_area_ratio_classify_unit_defines.svh"
module tbar_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input tbar_pkg::tri_in_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input tbar_pkg::tri_out_t out_data_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [31:0]        cfg_data_i
);
  import tbar_pkg::*;

  logic unused_in;
  assign unused_in = in_valid_i ^ (|in_data_i) ^ cfg_valid_i ^ (|cfg_data_i);

  // a stalled result word holds
  `TBAR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  // input side frees up exactly when the output register can move
  `TBAR_ASSERT_ALWAYS(a_in_ready, clk_i, rst_ni, in_ready_o == (!out_valid_o || out_ready_i))
  // threshold register never back-pressures
  `TBAR_ASSERT_ALWAYS(a_cfg_ready, clk_i, rst_ni, cfg_ready_o)
  // a selected triangle has a nonzero ratio
  `TBAR_ASSERT_ALWAYS(a_sel_ratio, clk_i, rst_ni, !(out_valid_o && out_data_o.selected) || (out_data_o.area_ratio != '0))
  // zero ratio gives zero key
  `TBAR_ASSERT_ALWAYS(a_zero_key, clk_i, rst_ni, !(out_valid_o && out_data_o.area_ratio == '0) || (out_data_o.priority_key == '0))

endmodule

bind triangle_box_area_ratio_classify_unit tbar_checker u_tbar_checker (.*);
`default_nettype wire
